### src/bqc_pkg.sv
// Shared types, widths and control codes of the cascaded biquad filter.
// No dependencies; every other file of the block imports this package.
package bqc_pkg;

	localparam int DATA_W            = 16;
	localparam int OUT_W             = 12;
	localparam int COEF_W            = 16;
	localparam int PROD_W            = 32;
	localparam int ACC_W             = 34;
	localparam int FRAC_SHIFT        = 11;
	localparam int OUT_SHIFT         = 4;
	localparam int MAX_SECTIONS      = 2;
	localparam int DEF_SECTION_COUNT = 2;
	localparam int APB_ADDR_W        = 6;
	localparam int APB_DATA_W        = 64;
	localparam int REG_IDX_W         = 3;
	localparam int UC_ADDR_W         = 4;

	// Register indexes (byte address is eight times the index).
	localparam logic [REG_IDX_W-1:0] REG_SEC0_FWD  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SEC0_FBK  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SEC0_GAIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SEC1_FWD  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SEC1_FBK  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SEC1_GAIN = 3'd5;

	// Multiplier operand pairs.
	localparam logic [2:0] MUL_NONE = 3'd0;
	localparam logic [2:0] MUL_A1W1 = 3'd1;
	localparam logic [2:0] MUL_A2W2 = 3'd2;
	localparam logic [2:0] MUL_B0W  = 3'd3;
	localparam logic [2:0] MUL_B1W1 = 3'd4;
	localparam logic [2:0] MUL_B2W2 = 3'd5;
	localparam logic [2:0] MUL_VG   = 3'd6;

	// Accumulator operations.
	localparam logic [2:0] ACC_HOLD   = 3'd0;
	localparam logic [2:0] ACC_LOAD_X = 3'd1;
	localparam logic [2:0] ACC_LOAD_P = 3'd2;
	localparam logic [2:0] ACC_ADD_P  = 3'd3;
	localparam logic [2:0] ACC_SUB_P  = 3'd4;

	// Write-back targets of the shifted accumulator value.
	localparam logic [1:0] WB_NONE = 2'd0;
	localparam logic [1:0] WB_W    = 2'd1;
	localparam logic [1:0] WB_V    = 2'd2;
	localparam logic [1:0] WB_Y    = 2'd3;

	localparam logic [UC_ADDR_W-1:0] UC_SEC_START = '0;

	typedef struct packed {
		logic [2:0]           mul_sel;
		logic [2:0]           acc_op;
		logic [1:0]           wb;
		logic                 last;
		logic [UC_ADDR_W-1:0] jump;
	} ucw_t;

	typedef struct packed {
		logic [MAX_SECTIONS-1:0][3*COEF_W-1:0] fwd;
		logic [MAX_SECTIONS-1:0][2*COEF_W-1:0] fbk;
		logic [MAX_SECTIONS-1:0][COEF_W-1:0]   gain;
	} cfg_t;

endpackage

### src/biquad_cascade_iir_fixed.sv
// Top level of the cascaded direct-form-II biquad filter: sequencer and handshakes.
// Depends on bqc_pkg, bqc_ucode_rom, bqc_cfg_regs and bqc_datapath.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_stall    sample_in  (signed 16)
//   output    out        out_valid / out_stall  sample_out (signed 12)
//   config    in/out     APB psel/penable       paddr, pwdata, prdata (64-bit data)
//
// An item is accepted when the block is idle; it then runs nine microcode steps per
// section through one shared 16x16 multiplier and a 34-bit accumulator, and the block
// stays busy, taking no new item, until the last step of the last section registers
// the result.
// The result sits in an output register; while it is stalled the block still accepts
// and computes the next item, and holds in the final step if the old result is not
// yet taken. Reset clears the configuration registers, the delay words and control.
module biquad_cascade_iir_fixed
	import bqc_pkg::*;
#(
	parameter int SECTION_COUNT = DEF_SECTION_COUNT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] sample_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  sample_out,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0]    pwdata,
	output logic [APB_DATA_W-1:0]    prdata,
	output logic                     pready
);

	localparam int SEC_W = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;

	logic                     busy_q;
	logic [UC_ADDR_W-1:0]     step_q;
	logic [SEC_W-1:0]         sec_q;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  sample_out_q;

	ucw_t                     ucw;
	cfg_t                     cfg;
	logic signed [DATA_W-1:0] y_nxt;
	logic                     in_acc;
	logic                     more;
	logic                     finish;
	logic                     hold;
	logic                     adv;

	assign pready     = 1'b1;
	assign in_stall   = busy_q;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	assign in_acc = in_valid && !busy_q;
	assign more   = (sec_q != SEC_W'(SECTION_COUNT - 1));
	assign finish = busy_q && ucw.last && !more;
	// Hold the last step while the previous result still waits downstream.
	assign hold   = finish && out_valid_q && out_stall;
	assign adv    = busy_q && !hold;

	bqc_ucode_rom u_rom (
		.addr (step_q),
		.ucw  (ucw)
	);

	bqc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	bqc_datapath #(
		.SECTION_COUNT (SECTION_COUNT),
		.SEC_W         (SEC_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ucw       (ucw),
		.en        (adv),
		.sec       (sec_q),
		.load      (in_acc),
		.sample_in (sample_in),
		.y_nxt     (y_nxt)
	);

	// Step counter with a conditional jump back to the section entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= UC_SEC_START;
			sec_q  <= '0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			step_q <= UC_SEC_START;
			sec_q  <= '0;
		end else if (adv) begin
			if (ucw.last) begin
				if (more) begin
					sec_q  <= sec_q + SEC_W'(1);
					step_q <= ucw.jump;
				end else begin
					busy_q <= 1'b0;
				end
			end else begin
				step_q <= step_q + UC_ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && adv) begin
			sample_out_q <= y_nxt[OUT_SHIFT +: OUT_W];
		end
	end

endmodule

### src/bqc_ucode_rom.sv
// Microcode store of the biquad sequencer: one control word per step.
// Depends on bqc_pkg.
module bqc_ucode_rom
	import bqc_pkg::*;
(
	input  logic [UC_ADDR_W-1:0] addr,
	output ucw_t                 ucw
);

	// One section takes nine steps; each product is registered and then consumed by the step that follows it.
	always_comb begin
		ucw = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, wb: WB_NONE, last: 1'b0, jump: UC_SEC_START};
		case (addr)
			4'd0: begin
				ucw.acc_op  = ACC_LOAD_X;
				ucw.mul_sel = MUL_A1W1;
			end
			4'd1: begin
				ucw.acc_op  = ACC_SUB_P;
				ucw.mul_sel = MUL_A2W2;
			end
			4'd2: begin
				ucw.acc_op = ACC_SUB_P;
				ucw.wb     = WB_W;
			end
			4'd3: begin
				ucw.mul_sel = MUL_B0W;
			end
			4'd4: begin
				ucw.acc_op  = ACC_LOAD_P;
				ucw.mul_sel = MUL_B1W1;
			end
			4'd5: begin
				ucw.acc_op  = ACC_ADD_P;
				ucw.mul_sel = MUL_B2W2;
			end
			4'd6: begin
				ucw.acc_op = ACC_ADD_P;
				ucw.wb     = WB_V;
			end
			4'd7: begin
				ucw.mul_sel = MUL_VG;
			end
			4'd8: begin
				ucw.acc_op = ACC_LOAD_P;
				ucw.wb     = WB_Y;
				ucw.last   = 1'b1;
				ucw.jump   = UC_SEC_START;
			end
			default: begin
				ucw.acc_op = ACC_HOLD;
			end
		endcase
	end

endmodule

### src/bqc_cfg_regs.sv
// APB-style configuration registers holding coefficients and gains.
// Depends on bqc_pkg.
module bqc_cfg_regs
	import bqc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx   = paddr[APB_ADDR_W-1 -: REG_IDX_W];
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SEC0_FWD:  cfg_q.fwd[0]  <= pwdata[3*COEF_W-1:0];
				REG_SEC0_FBK:  cfg_q.fbk[0]  <= pwdata[2*COEF_W-1:0];
				REG_SEC0_GAIN: cfg_q.gain[0] <= pwdata[COEF_W-1:0];
				REG_SEC1_FWD:  cfg_q.fwd[1]  <= pwdata[3*COEF_W-1:0];
				REG_SEC1_FBK:  cfg_q.fbk[1]  <= pwdata[2*COEF_W-1:0];
				REG_SEC1_GAIN: cfg_q.gain[1] <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SEC0_FWD:  prdata = APB_DATA_W'(cfg_q.fwd[0]);
			REG_SEC0_FBK:  prdata = APB_DATA_W'(cfg_q.fbk[0]);
			REG_SEC0_GAIN: prdata = APB_DATA_W'(cfg_q.gain[0]);
			REG_SEC1_FWD:  prdata = APB_DATA_W'(cfg_q.fwd[1]);
			REG_SEC1_FBK:  prdata = APB_DATA_W'(cfg_q.fbk[1]);
			REG_SEC1_GAIN: prdata = APB_DATA_W'(cfg_q.gain[1]);
			default:       prdata = '0;
		endcase
	end

endmodule

### src/bqc_datapath.sv
// Shared multiply-accumulate datapath with the per-section delay words.
// Depends on bqc_pkg; driven by control words from bqc_ucode_rom.
module bqc_datapath
	import bqc_pkg::*;
#(
	parameter int SECTION_COUNT = DEF_SECTION_COUNT,
	parameter int SEC_W         = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  ucw_t                     ucw,
	input  logic                     en,
	input  logic [SEC_W-1:0]         sec,
	input  logic                     load,
	input  logic signed [DATA_W-1:0] sample_in,
	output logic signed [DATA_W-1:0] y_nxt
);

	logic signed [DATA_W-1:0] w1_q [SECTION_COUNT];
	logic signed [DATA_W-1:0] w2_q [SECTION_COUNT];
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] w_q;
	logic signed [DATA_W-1:0] v_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic [3*COEF_W-1:0]      fwd_sel;
	logic [2*COEF_W-1:0]      fbk_sel;
	logic [COEF_W-1:0]        gain_sel;
	logic signed [DATA_W-1:0] w1_sel;
	logic signed [DATA_W-1:0] w2_sel;
	logic signed [COEF_W-1:0] mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_nxt;

	always_comb begin
		fwd_sel  = '0;
		fbk_sel  = '0;
		gain_sel = '0;
		w1_sel   = '0;
		w2_sel   = '0;
		for (int i = 0; i < SECTION_COUNT; i++) begin
			if (sec == SEC_W'(i)) begin
				fwd_sel  = cfg.fwd[i];
				fbk_sel  = cfg.fbk[i];
				gain_sel = cfg.gain[i];
				w1_sel   = w1_q[i];
				w2_sel   = w2_q[i];
			end
		end
	end

	always_comb begin
		case (ucw.mul_sel)
			MUL_A1W1: begin mul_a = fbk_sel[COEF_W-1:0];           mul_b = w1_sel; end
			MUL_A2W2: begin mul_a = fbk_sel[2*COEF_W-1:COEF_W];    mul_b = w2_sel; end
			MUL_B0W:  begin mul_a = fwd_sel[COEF_W-1:0];           mul_b = w_q;    end
			MUL_B1W1: begin mul_a = fwd_sel[2*COEF_W-1:COEF_W];    mul_b = w1_sel; end
			MUL_B2W2: begin mul_a = fwd_sel[3*COEF_W-1:2*COEF_W];  mul_b = w2_sel; end
			MUL_VG:   begin mul_a = gain_sel;                      mul_b = v_q;    end
			default:  begin mul_a = '0;                            mul_b = '0;     end
		endcase
	end

	assign prod_c   = mul_a * mul_b;
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	always_comb begin
		case (ucw.acc_op)
			ACC_LOAD_X: acc_nxt = {{(ACC_W-DATA_W){x_q[DATA_W-1]}}, x_q};
			ACC_LOAD_P: acc_nxt = prod_ext;
			ACC_ADD_P:  acc_nxt = acc_q + prod_ext;
			ACC_SUB_P:  acc_nxt = acc_q - prod_ext;
			default:    acc_nxt = acc_q;
		endcase
	end

	// Arithmetic shift right followed by a 16-bit wrap is a plain bit slice.
	assign y_nxt = acc_nxt[FRAC_SHIFT +: DATA_W];

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= sample_in;
		end else if (en && ucw.wb == WB_Y) begin
			x_q <= y_nxt;
		end
		if (en) begin
			acc_q <= acc_nxt;
			if (ucw.mul_sel != MUL_NONE) begin
				prod_q <= prod_c;
			end
			if (ucw.wb == WB_W) begin
				w_q <= y_nxt;
			end
			if (ucw.wb == WB_V) begin
				v_q <= y_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SECTION_COUNT; i++) begin
				w1_q[i] <= '0;
				w2_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < SECTION_COUNT; i++) begin
				if (en && ucw.wb == WB_Y && sec == SEC_W'(i)) begin
					w2_q[i] <= w1_q[i];
					w1_q[i] <= w_q;
				end
			end
		end
	end

endmodule

### src/bqc_checker.sv
// Port-level checker of the cascaded biquad filter and its bind to the top level.
// Depends on bqc_pkg and on biquad_cascade_iir_fixed.
module bqc_checker
	import bqc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] sample_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(sample_out))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after taking an item");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in progress");

endmodule

bind biquad_cascade_iir_fixed bqc_checker u_bqc_checker (.*);
